/* design/lfrc_pkg.sv */
// ----------------------------------------------------------------------------
// lfrc_pkg: shared types and constants for the length-framed receiver
// Word layouts for the receive and result channels, op codes and fixed
// frame positions.
// ----------------------------------------------------------------------------
package lfrc_pkg;

    // op codes of an incoming word
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // fixed frame positions
    localparam int LEN_HI_POS   = 8;   // big-endian length, high byte
    localparam int LEN_LO_POS   = 9;   // big-endian length, low byte
    localparam int HDR_CHK_POS  = 10;  // header checksum byte
    localparam int PAYLOAD_POS  = 11;  // first payload byte

    // receive word
    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [7:0] byte_index;
        logic       frame_done;
        logic       frame_ok;
        logic       overflow;
    } out_word_t;

endpackage

/* design/length_framed_receiver_with_checksums_top.sv */
// ----------------------------------------------------------------------------
// length_framed_receiver_with_checksums_top: serial frame receiver
// Counts frame bytes, extracts the length and checks header and payload
// two's complement sums.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel (rx_valid, rx_stall, rx_word) carries one word per received
//   byte or a restart command. res channel (res_valid, res_stall, res_word)
//   returns exactly one result word per rx word, in order.
//   A word is taken on a rising edge with valid high and stall low.
//   An accepted word passes the input register, then the result register
//   (res_valid). Throughput: one word per cycle while res_stall is low; the
//   frame state update is one add and compare per byte in the step unit.
//   Reset clears the frame state and both pipeline valid flags; the block is
//   ready for a word in the first cycle after reset.
//   When res_stall is high with a result held, the input register keeps its
//   word and rx_stall rises once that register is full; nothing is dropped.
//   Frame capacity is MAX_FRAME bytes; bytes past it set overflow.
// ----------------------------------------------------------------------------
module length_framed_receiver_with_checksums_top #(
    parameter int MAX_FRAME = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_stall,
    input  lfrc_pkg::in_word_t  rx_word,
    output logic                res_valid,
    input  logic                res_stall,
    output lfrc_pkg::out_word_t res_word
);
    import lfrc_pkg::*;

    logic      in_v_reg;
    in_word_t  in_w_reg;
    logic      res_v_reg;
    out_word_t res_w_reg;
    out_word_t step_res;
    logic      advance;
    logic      accept;

    // move a word to the result register when it is free or being taken
    assign advance  = in_v_reg && (!res_v_reg || !res_stall);
    assign rx_stall = in_v_reg && !advance;
    assign accept   = rx_valid && !rx_stall;

    // frame state and per-byte logic
    lfrc_step #(
        .MAX_FRAME(MAX_FRAME)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .word    (in_w_reg),
        .res     (step_res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (accept)
            in_v_reg <= 1'b1;
        else if (advance)
            in_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_w_reg <= rx_word;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_v_reg <= 1'b0;
        else if (advance)
            res_v_reg <= 1'b1;
        else if (!res_stall)
            res_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_w_reg <= step_res;
    end

    assign res_valid = res_v_reg;
    assign res_word  = res_w_reg;

endmodule

/* design/lfrc_step.sv */
// ----------------------------------------------------------------------------
// lfrc_step: frame state and per-byte update
// Holds the byte count, length and running sums; computes the result word
// for one byte and commits the new state when step_en is high.
// ----------------------------------------------------------------------------
module lfrc_step #(
    parameter int MAX_FRAME = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  lfrc_pkg::in_word_t  word,
    output lfrc_pkg::out_word_t res
);
    import lfrc_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam int LW = (CW > 17) ? CW : 17;

    logic [CW-1:0] count_reg, count_next;
    logic [15:0]   len_reg, len_next;
    logic [7:0]    hdr_sum_reg, hdr_sum_next;
    logic [7:0]    pay_sum_reg, pay_sum_next;
    logic          ok_reg, ok_next;
    logic          done_reg, done_next;
    logic          ovf_reg, ovf_next;

    logic [LW-1:0] pos;
    logic [LW-1:0] last_pos;
    logic [7:0]    pay_total;
    logic [7:0]    idx;
    logic          done_now;

    assign pos       = LW'(count_reg);
    assign last_pos  = LW'(len_reg) + LW'(HDR_CHK_POS);
    assign pay_total = pay_sum_reg + word.data_byte;

    // next state and result for one byte
    always_comb
    begin
        count_next   = count_reg;
        len_next     = len_reg;
        hdr_sum_next = hdr_sum_reg;
        pay_sum_next = pay_sum_reg;
        ok_next      = ok_reg;
        done_next    = done_reg;
        ovf_next     = ovf_reg;
        done_now     = 1'b0;
        idx          = pos[7:0];

        if (word.op == OP_RESTART)
        begin
            count_next   = '0;
            len_next     = '0;
            hdr_sum_next = '0;
            pay_sum_next = '0;
            ok_next      = 1'b0;
            done_next    = 1'b0;
            ovf_next     = 1'b0;
            idx          = '0;
        end
        else if (done_reg)
        begin
            // frame complete, byte ignored
        end
        else if (count_reg == CW'(MAX_FRAME))
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            count_next = count_reg + CW'(1);
            if (pos <= LW'(HDR_CHK_POS))
                hdr_sum_next = hdr_sum_reg + word.data_byte;
            if (pos == LW'(LEN_HI_POS))
                len_next = {word.data_byte, len_reg[7:0]};
            else if (pos == LW'(LEN_LO_POS))
                len_next = {len_reg[15:8], word.data_byte};

            if (pos == LW'(HDR_CHK_POS) && len_reg == 16'd0)
            begin
                // zero length counts as a complete bad frame
                done_now  = 1'b1;
                done_next = 1'b1;
                ovf_next  = 1'b1;
            end
            else if (pos >= LW'(PAYLOAD_POS))
            begin
                if (pos == last_pos)
                begin
                    done_now  = 1'b1;
                    done_next = 1'b1;
                    if (hdr_sum_reg == 8'd0 && pay_total == 8'd0)
                        ok_next = 1'b1;
                end
                else
                begin
                    pay_sum_next = pay_total;
                end
            end
        end

        res.byte_index = idx;
        res.frame_done = done_now;
        res.frame_ok   = ok_next;
        res.overflow   = ovf_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            len_reg     <= '0;
            hdr_sum_reg <= '0;
            pay_sum_reg <= '0;
            ok_reg      <= 1'b0;
            done_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            count_reg   <= count_next;
            len_reg     <= len_next;
            hdr_sum_reg <= hdr_sum_next;
            pay_sum_reg <= pay_sum_next;
            ok_reg      <= ok_next;
            done_reg    <= done_next;
            ovf_reg     <= ovf_next;
        end
    end

endmodule

/* design/lfrc_check.sv */
// ----------------------------------------------------------------------------
// lfrc_check: port-level checks for the length-framed receiver
// Watches the top level's channels and flags handshake faults and results
// that the frame logic can never produce.
// ----------------------------------------------------------------------------
module lfrc_check (
    input logic                clk,
    input logic                rst_n,
    input logic                rx_valid,
    input logic                rx_stall,
    input lfrc_pkg::in_word_t  rx_word,
    input logic                res_valid,
    input logic                res_stall,
    input lfrc_pkg::out_word_t res_word
);
    import lfrc_pkg::*;

    logic last_ok_reg;

    // frame_ok of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_ok_reg <= 1'b0;
        else if (res_valid && !res_stall)
            last_ok_reg <= res_word.frame_ok;
    end

    // held result stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_word))
        else $error("result word changed while stalled");

    // a new result comes from an rx word accepted via both pipeline registers
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(rx_valid && !rx_stall, 2))
        else $error("result without a matching rx word");

    // a good frame and an overflow never show together
    a_ok_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_word.frame_ok && res_word.overflow))
        else $error("frame_ok and overflow both set");

    // frame_ok only appears on the completing byte or stays from before
    a_ok_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && res_word.frame_ok && !res_word.frame_done
        |-> last_ok_reg)
        else $error("frame_ok set without a completed frame");

endmodule

bind length_framed_receiver_with_checksums_top lfrc_check u_lfrc_check (.*);

/* verif/length_framed_receiver_with_checksums_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_framed_receiver_with_checksums_top_test: frame receiver testbench
// Drives framed byte streams with random gaps and result stalls, predicts
// every status word from a behavioral copy of the frame state and checks
// each returned word field by field, in order.
// ----------------------------------------------------------------------------
module length_framed_receiver_with_checksums_top_test;

    import lfrc_pkg::*;

    localparam int FRAME_CAP   = 256;
    localparam int WORD_TARGET = 1400;
    localparam int STALL_LIMIT = 2000;

    logic      clk;
    logic      rst_n;
    logic      rx_valid;
    logic      rx_stall;
    in_word_t  rx_word;
    logic      res_valid;
    logic      res_stall;
    out_word_t res_word;

    // expected status words, oldest first
    out_word_t expected_status[$];
    out_word_t want;
    int        status_errors = 0;
    int        words_sent    = 0;
    int        res_hold      = 0;
    int        quiet_cycles  = 0;
    bit        rx_idle_on    = 1'b1;
    bit        res_idle_on   = 1'b1;

    // behavioral frame state
    int unsigned rx_count;
    logic [15:0] frame_len;
    logic [7:0]  hdr_sum;
    logic [7:0]  pay_sum;
    logic        ok_seen;
    logic        frame_closed;
    logic        ovf_seen;

    length_framed_receiver_with_checksums_top #(
        .MAX_FRAME (FRAME_CAP)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_word   (rx_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // clear the frame state, as after reset or restart
    function automatic void clear_frame_state();
        rx_count     = 0;
        frame_len    = '0;
        hdr_sum      = '0;
        pay_sum      = '0;
        ok_seen      = 1'b0;
        frame_closed = 1'b0;
        ovf_seen     = 1'b0;
    endfunction

    // advance the frame state by one word and return the status it produces
    function automatic out_word_t predict_status(in_word_t w);
        out_word_t   r;
        int unsigned pos;
        logic        closes;
        logic [7:0]  last_sum;
        pos    = 0;
        closes = 1'b0;
        if (w.op == OP_RESTART)
        begin
            clear_frame_state();
        end
        else if (frame_closed)
        begin
            pos = rx_count;
        end
        else if (rx_count >= FRAME_CAP)
        begin
            pos      = rx_count;
            ovf_seen = 1'b1;
        end
        else
        begin
            pos      = rx_count;
            rx_count = pos + 1;
            if (pos <= HDR_CHK_POS)
                hdr_sum = hdr_sum + w.data_byte;
            if (pos == LEN_HI_POS)
                frame_len[15:8] = w.data_byte;
            else if (pos == LEN_LO_POS)
                frame_len[7:0] = w.data_byte;
            if (pos == HDR_CHK_POS && frame_len == 16'd0)
            begin
                // zero length closes the frame as bad
                closes       = 1'b1;
                frame_closed = 1'b1;
                ovf_seen     = 1'b1;
            end
            else if (pos >= PAYLOAD_POS)
            begin
                if (pos == frame_len + HDR_CHK_POS)
                begin
                    closes       = 1'b1;
                    frame_closed = 1'b1;
                    last_sum     = pay_sum + w.data_byte;
                    if (hdr_sum == 8'd0 && last_sum == 8'd0)
                        ok_seen = 1'b1;
                end
                else
                begin
                    pay_sum = pay_sum + w.data_byte;
                end
            end
        end
        r.byte_index = pos[7:0];
        r.frame_done = closes;
        r.frame_ok   = ok_seen;
        r.overflow   = ovf_seen;
        return r;
    endfunction

    // send one word after a random gap and record its expected status
    task automatic send_word(input logic op, input logic [7:0] data, input bit ignored = 1'b0);
        in_word_t w;
        int       gap;
        w.op        = op;
        w.data_byte = data;
        gap = rx_idle_on ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_word  <= w;
        do @(posedge clk); while (rx_stall);
        expected_status.push_back(predict_status(w));
        if (!ignored)
            words_sent++;
    endtask

    // restart with random filler in the data byte
    task automatic send_restart();
        send_word(OP_RESTART, 8'($urandom));
    endtask

    // full frame: restart, preamble, length, header check, payload, payload check
    // pre_kind 0 = random preamble, 1 = all zero, 2 = all ones
    task automatic send_frame(input logic [15:0] len, input int pre_kind,
                              input bit bad_hdr, input bit bad_pay, input int tail);
        logic [7:0] hsum;
        logic [7:0] psum;
        logic [7:0] b;
        int         last_pos;
        bit         fits;
        int         i;
        hsum = '0;
        psum = '0;
        fits = (len == 16'd0) || (int'(len) + HDR_CHK_POS <= FRAME_CAP - 1);
        send_restart();
        for (i = 0; i < LEN_HI_POS; i++)
        begin
            b = (pre_kind == 1) ? 8'h00 : (pre_kind == 2) ? 8'hFF : 8'($urandom);
            hsum = hsum + b;
            send_word(OP_BYTE, b);
        end
        hsum = hsum + len[15:8] + len[7:0];
        send_word(OP_BYTE, len[15:8]);
        send_word(OP_BYTE, len[7:0]);
        b = 8'(-hsum);
        if (bad_hdr)
            b = b ^ 8'(1 << $urandom_range(0, 7));
        send_word(OP_BYTE, b);
        if (len != 16'd0)
        begin
            // oversize frames run a few bytes past capacity
            last_pos = fits ? int'(len) + HDR_CHK_POS : FRAME_CAP + 2;
            for (i = PAYLOAD_POS; i < last_pos; i++)
            begin
                b    = 8'($urandom);
                psum = psum + b;
                send_word(OP_BYTE, b);
            end
            if (fits)
            begin
                b = 8'(-psum);
                if (bad_pay)
                    b = b ^ 8'(1 << $urandom_range(0, 7));
            end
            else
            begin
                b = 8'($urandom);
            end
            send_word(OP_BYTE, b);
        end
        // trailing bytes: ignored once the frame is closed
        for (i = 0; i < tail; i++)
            send_word(OP_BYTE, 8'($urandom), fits);
    endtask

    // restart handling, including restart during a frame
    task automatic test_restart();
        send_word(OP_RESTART, 8'hFF);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_RESTART, 8'h00);
    endtask

    // zero length closes at the header check byte as a bad frame
    task automatic test_zero_length();
        send_frame(16'd0, 2, 1'b0, 1'b0, 2);
    endtask

    // shortest good frame: the payload check byte is the only payload byte
    task automatic test_single_byte_payload();
        send_frame(16'd1, 1, 1'b0, 1'b0, 1);
    endtask

    // header and payload sum errors, alone and together, then a clean frame
    task automatic test_checksum_errors();
        send_frame(16'($urandom_range(2, 12)), 0, 1'b1, 1'b0, 1);
        send_frame(16'($urandom_range(2, 12)), 0, 1'b0, 1'b1, 1);
        send_frame(16'($urandom_range(1, 12)), 0, 1'b1, 1'b1, 0);
        send_frame(16'($urandom_range(1, 12)), 0, 1'b0, 1'b0, 1);
    endtask

    // largest fitting frame, then lengths that run past capacity
    task automatic test_capacity();
        send_frame(16'(FRAME_CAP - PAYLOAD_POS), 0, 1'b0, 1'b0, 2);
        send_frame(16'(FRAME_CAP - HDR_CHK_POS), 0, 1'b0, 1'b0, 2);
        send_frame(16'hFFFF, 0, 1'b0, 1'b0, 1);
    endtask

    // mostly well-formed frames with random content, some broken streams
    task automatic test_random_traffic();
        int          kind;
        int          n;
        int          i;
        logic [15:0] len;
        while (words_sent < WORD_TARGET)
        begin
            rx_idle_on  = ($urandom_range(0, 3) != 0);
            res_idle_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 3)
                len = 16'd0;
            else if (kind < 5)
                len = 16'($urandom_range(FRAME_CAP - HDR_CHK_POS, 65535));
            else if (kind < 8)
                len = 16'($urandom_range(200, FRAME_CAP - PAYLOAD_POS));
            else
                len = 16'($urandom_range(1, 24));
            if (kind >= 88 && kind < 94)
            begin
                // frame cut short by a restart
                send_restart();
                n = $urandom_range(1, 15);
                for (i = 0; i < n; i++)
                    send_word(OP_BYTE, 8'($urandom));
            end
            else if (kind >= 94)
            begin
                // unstructured words with the occasional restart
                n = $urandom_range(1, 20);
                for (i = 0; i < n; i++)
                    send_word(($urandom_range(0, 7) == 0) ? OP_RESTART : OP_BYTE,
                              8'($urandom));
            end
            else
            begin
                send_frame(len, 0, ($urandom_range(0, 9) == 0),
                           ($urandom_range(0, 9) == 0), $urandom_range(0, 3));
            end
        end
        rx_idle_on  = 1'b1;
        res_idle_on = 1'b1;
    endtask

    // result side stall pattern, redrawn after every accepted word
    always @(negedge clk)
    begin
        if (res_hold > 0)
        begin
            res_stall <= 1'b1;
            res_hold  = res_hold - 1;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    // compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_status.size() == 0)
            begin
                $error("result word with nothing expected: %p", res_word);
                status_errors++;
            end
            else
            begin
                want = expected_status.pop_front();
                if (res_word.byte_index !== want.byte_index)
                begin
                    $error("byte_index: expected %0d, got %0d",
                           want.byte_index, res_word.byte_index);
                    status_errors++;
                end
                if (res_word.frame_done !== want.frame_done)
                begin
                    $error("frame_done: expected %0b, got %0b",
                           want.frame_done, res_word.frame_done);
                    status_errors++;
                end
                if (res_word.frame_ok !== want.frame_ok)
                begin
                    $error("frame_ok: expected %0b, got %0b",
                           want.frame_ok, res_word.frame_ok);
                    status_errors++;
                end
                if (res_word.overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, got %0b",
                           want.overflow, res_word.overflow);
                    status_errors++;
                end
            end
            res_hold = res_idle_on ? $urandom_range(0, 7) : 0;
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((rx_valid && !rx_stall) || (res_valid && !res_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        rst_n     = 1'b0;
        rx_valid  = 1'b0;
        rx_word   = '0;
        res_stall = 1'b0;
        clear_frame_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_restart();
        test_zero_length();
        test_single_byte_payload();
        test_checksum_errors();
        test_capacity();
        test_random_traffic();

        // drain, then let the pipeline settle
        @(negedge clk);
        rx_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (status_errors == 0 && expected_status.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
